// ----- hdl/hct_pkg.sv -----
// Shared types, register indexes and the period table of the console timer.
`timescale 1ns / 1ps
`default_nettype none

package hct_pkg;

  localparam int unsigned CyclesW = 8;
  localparam int unsigned CountW  = 8;
  localparam int unsigned PeriodW = 11;
  localparam int unsigned SelW    = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TIMER_ENABLE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLOCK_SELECT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RELOAD_VALUE = 2'd2;

  // Clock select codes
  localparam logic [SelW-1:0] SEL_1024 = 2'd0;
  localparam logic [SelW-1:0] SEL_16   = 2'd1;
  localparam logic [SelW-1:0] SEL_64   = 2'd2;
  localparam logic [SelW-1:0] SEL_256  = 2'd3;

  localparam logic [CountW-1:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic              enable;
    logic [SelW-1:0]   select;
    logic [CountW-1:0] reload;
  } hct_cfg_t;

  typedef struct packed {
    logic [PeriodW-1:0] period_left;
    logic [SelW-1:0]    seen_select;
  } hct_stat_t;

  function automatic logic [PeriodW-1:0] hct_period(input logic [SelW-1:0] sel);
    logic [PeriodW-1:0] p;
    p = 11'd1024;
    case (sel)
      SEL_1024: p = 11'd1024;
      SEL_16:   p = 11'd16;
      SEL_64:   p = 11'd64;
      SEL_256:  p = 11'd256;
      default:  p = 11'd1024;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/handheld_console_timer_top.sv -----
// Top level of the handheld console divider and timer block.
//
// Usage:
//   Slave stream: one transfer per retired instruction, tdata[7:0] holds the
//   machine cycles that instruction used. Master stream: one transfer per
//   input transfer with the divider value, timer value and overflow pulse
//   after that instruction.
//   Configuration: a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i);
//   index 0 timer enable, 1 clock select, 2 reload value. Write only while
//   no transfer is in flight.
// Pipeline:
//   An accepted item waits in the input register; when the result register
//   is free, the state steps and the result register captures the result.
//   One item per clock is sustained while the receiver keeps up: the divider
//   add and the period compare/subtract fit in the single step.
// Reset:
//   rst_ni clears both stage valids, the configuration (timer off, select
//   1024, reload 0), the divider and timer counts, and presets the period
//   down-counter to 1024. No clearing pass is needed.
// Stall:
//   When m_axis_tready_i is low the result register holds; the input
//   register still takes one more item, then s_axis_tready_o drops.
`timescale 1ns / 1ps
`default_nettype none

module handheld_console_timer_top
  import hct_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  // Input stream
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [7:0]         s_axis_tdata_i,  // [7:0] elapsed_cycles
  // Result stream
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic      [23:0]        m_axis_tdata_o   // [7:0] div_value, [15:8] timer_value,
                                                   // [16] timer_irq, [23:17] zero
);

  hct_cfg_t           cfg_q;
  hct_stat_t          tmr_stat;
  logic               in_valid_q;
  logic [CyclesW-1:0] in_cycles_q;
  logic               out_valid_q;
  logic [CountW-1:0]  out_div_q, out_timer_q;
  logic               out_irq_q;
  logic               advance;
  logic [CountW-1:0]  div_d, timer_d;
  logic               irq_d;

  // Configuration registers; unknown index does nothing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable <= 1'b0;
      cfg_q.select <= SEL_1024;
      cfg_q.reload <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIMER_ENABLE: cfg_q.enable <= cfg_data_i[0];
        CFG_CLOCK_SELECT: cfg_q.select <= cfg_data_i[SelW-1:0];
        CFG_RELOAD_VALUE: cfg_q.reload <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Move the held item into the result register when that slot frees up
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_cycles_q <= s_axis_tdata_i[CyclesW-1:0];
    end
  end

  // Step the divider and timer state once per item
  hct_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .cycles_i (in_cycles_q),
    .div_d_o  (div_d)
  );

  hct_timer u_timer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .cycles_i  (in_cycles_q),
    .cfg_i     (cfg_q),
    .timer_d_o (timer_d),
    .irq_o     (irq_d),
    .stat_o    (tmr_stat)
  );

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_div_q   <= div_d;
      out_timer_q <= timer_d;
      out_irq_q   <= irq_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_irq_q, out_timer_q, out_div_q};

  // The period down-counter never rests at zero
  a_period_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tmr_stat.period_left != '0)
    else $error("period down-counter reached zero");

  // The period down-counter never exceeds the longest period
  a_period_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tmr_stat.period_left <= 11'd1024)
    else $error("period down-counter above longest period");

  // An overflow step leaves a full period for the select in use
  a_irq_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && irq_d) |=> tmr_stat.period_left == hct_period(tmr_stat.seen_select))
    else $error("overflow did not reload the period");

  // A stalled result keeps the held input item in place
  a_input_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |=>
      (in_valid_q && $stable(in_cycles_q)))
    else $error("held input item lost during stall");

endmodule

`default_nettype wire

// ----- hdl/hct_div.sv -----
// Free-running divider: cycle accumulator and 8-bit divider count.
`timescale 1ns / 1ps
`default_nettype none

module hct_div
  import hct_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [CyclesW-1:0] cycles_i,
  output logic      [CountW-1:0]  div_d_o
);

  logic [CyclesW-1:0] accum_q, accum_d;
  logic [CountW-1:0]  count_q;
  logic [CyclesW:0]   sum;

  // Accumulator plus one item stays below 512: at most one carry per step
  always_comb begin
    sum     = {1'b0, accum_q} + {1'b0, cycles_i};
    accum_d = sum[CyclesW-1:0];
    div_d_o = count_q + {{(CountW-1){1'b0}}, sum[CyclesW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      count_q <= '0;
    end else if (step_i) begin
      accum_q <= accum_d;
      count_q <= div_d_o;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hct_timer.sv -----
// Programmable timer: period down-counter, timer count and overflow pulse.
`timescale 1ns / 1ps
`default_nettype none

module hct_timer
  import hct_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [CyclesW-1:0] cycles_i,
  input  wire hct_cfg_t           cfg_i,
  output logic      [CountW-1:0]  timer_d_o,
  output logic                    irq_o,
  output hct_stat_t               stat_o
);

  logic [PeriodW-1:0] period_q, period_d, period_base, cyc_ext;
  logic [CountW-1:0]  timer_q;
  logic [SelW-1:0]    seen_q;

  always_comb begin
    // Reload the down-counter when the select changed, even when disabled
    period_base = (cfg_i.select != seen_q) ? hct_period(cfg_i.select) : period_q;
    cyc_ext     = {{(PeriodW-CyclesW){1'b0}}, cycles_i};
    period_d    = period_base;
    timer_d_o   = timer_q;
    irq_o       = 1'b0;
    if (cfg_i.enable) begin
      if (period_base <= cyc_ext) begin
        // Drop any overshoot: one increment per step at most
        period_d = hct_period(cfg_i.select);
        if (timer_q == COUNT_MAX) begin
          timer_d_o = cfg_i.reload;
          irq_o     = 1'b1;
        end else begin
          timer_d_o = timer_q + 8'd1;
        end
      end else begin
        period_d = period_base - cyc_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= 11'd1024;
      timer_q  <= '0;
      seen_q   <= SEL_1024;
    end else if (step_i) begin
      period_q <= period_d;
      timer_q  <= timer_d_o;
      seen_q   <= cfg_i.select;
    end
  end

  assign stat_o.period_left = period_q;
  assign stat_o.seen_select = seen_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the handheld console divider and timer block.
`timescale 1ns / 1ps

// One result transfer, packed as it travels in m_axis_tdata_o[16:0].
typedef struct packed {
  logic       irq;
  logic [7:0] timer;
  logic [7:0] div;
} timer_snapshot_t;

// Scoreboard: a shadow copy of the divider and timer with its own configuration.
class timer_scoreboard;
  // shadow configuration
  bit                 enable;
  bit [1:0]           select;
  bit [7:0]           reload;
  // shadow counters
  bit [7:0]           div_frac;
  bit [7:0]           div_ticks;
  bit [10:0]          period_left;
  bit [7:0]           tima;
  bit [1:0]           last_select;
  // periods indexed by the clock select code
  bit [10:0]          period_lut [4];
  timer_snapshot_t    pending_snapshots [$];
  int unsigned        errors;
  int unsigned        checked;
  int unsigned        irqs;

  function new();
    period_lut  = '{11'd1024, 11'd16, 11'd64, 11'd256};
    enable      = 1'b0;
    select      = hct_pkg::SEL_1024;
    reload      = 8'd0;
    div_frac    = 8'd0;
    div_ticks   = 8'd0;
    period_left = 11'd1024;
    tima        = 8'd0;
    last_select = hct_pkg::SEL_1024;
    errors      = 0;
    checked     = 0;
    irqs        = 0;
  endfunction

  function void write_register(bit [1:0] idx, bit [7:0] data);
    case (idx)
      hct_pkg::CFG_TIMER_ENABLE: enable = data[0];
      hct_pkg::CFG_CLOCK_SELECT: select = data[1:0];
      hct_pkg::CFG_RELOAD_VALUE: reload = data;
      default: ;
    endcase
  endfunction

  // Advance the shadow by one retired instruction and queue the snapshot it yields.
  function void note_instruction(bit [7:0] cycles);
    bit [8:0]        sum;
    timer_snapshot_t snap;
    sum = {1'b0, div_frac} + {1'b0, cycles};
    if (sum[8]) div_ticks = div_ticks + 8'd1;
    div_frac = sum[7:0];
    snap.irq = 1'b0;
    // a select change restarts the period even with the timer off
    if (select != last_select) begin
      period_left = period_lut[select];
      last_select = select;
    end
    if (enable) begin
      if (period_left <= {3'b000, cycles}) begin
        // overshoot is dropped: one increment per instruction at most
        period_left = period_lut[select];
        if (tima == hct_pkg::COUNT_MAX) begin
          tima     = reload;
          snap.irq = 1'b1;
        end else begin
          tima = tima + 8'd1;
        end
      end else begin
        period_left = period_left - {3'b000, cycles};
      end
    end
    snap.div   = div_ticks;
    snap.timer = tima;
    pending_snapshots.push_back(snap);
  endfunction

  function void check_snapshot(logic [23:0] word);
    timer_snapshot_t want;
    timer_snapshot_t got;
    got = word[16:0];
    if (pending_snapshots.size() == 0) begin
      $display("%0t: unexpected result transfer, actual %06h", $time, word);
      errors++;
      return;
    end
    want = pending_snapshots.pop_front();
    checked++;
    if (want.irq) irqs++;
    if (got.div !== want.div) begin
      $display("%0t: div_value expected %0d actual %0d", $time, want.div, got.div);
      errors++;
    end
    if (got.timer !== want.timer) begin
      $display("%0t: timer_value expected %0d actual %0d", $time, want.timer, got.timer);
      errors++;
    end
    if (got.irq !== want.irq) begin
      $display("%0t: timer_irq expected %0b actual %0b", $time, want.irq, got.irq);
      errors++;
    end
    if (word[23:17] !== 7'd0) begin
      $display("%0t: tdata padding expected 0 actual %02h", $time, word[23:17]);
      errors++;
    end
  endfunction
endclass

module tb;
  import hct_pkg::*;

  // index past the register list; a write there must change nothing
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned ITEMS_PER_PHASE = 110;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [7:0]         s_axis_tdata_i = '0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [23:0]        m_axis_tdata_o;

  timer_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned instructions_sent = 0;
  int unsigned reg_writes = 0;

  handheld_console_timer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run; the bound is many times the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: check every transfer against the oldest pending snapshot.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_snapshot(m_axis_tdata_o);
  end

  // Result side back-pressure: switch between stall patterns, including always-ready
  // stretches and long stalls.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned pattern_tick = 0;
  always @(negedge clk_i) begin
    pattern_tick <= pattern_tick + 1;
    if (pattern_tick % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= 1'($urandom_range(0, 1));
      2: m_axis_tready_i <= (pattern_tick % 3 != 0);
      default: begin
        if (stall_left != 0) begin
          stall_left      <= stall_left - 1;
          m_axis_tready_i <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_left      <= $urandom_range(8, 20);
          m_axis_tready_i <= 1'b0;
        end else begin
          m_axis_tready_i <= 1'b1;
        end
      end
    endcase
  end

  // Write one configuration register; the write lands on the next rising edge.
  task automatic program_register(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_register(idx, data);
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Send one instruction transfer; bursts of random length with random gaps.
  task automatic send_instruction(input logic [7:0] cycles);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        s_axis_tdata_i  <= 8'($urandom_range(0, 255));
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= cycles;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_instruction(cycles);
    instructions_sent++;
  endtask

  // Drop valid and wait until every snapshot is back and the pipe is quiet.
  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending_snapshots.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Cycle counts: mostly long instructions so the fast periods overflow often,
  // plus short ones and values right around the active period.
  function automatic logic [7:0] pick_cycles();
    int unsigned roll;
    int          near;
    roll = $urandom_range(0, 99);
    if (roll < 35) return 8'($urandom_range(0, 255));
    if (roll < 70) return 8'($urandom_range(200, 255));
    if (roll < 85) return 8'($urandom_range(0, 20));
    near = int'(sb.period_lut[sb.select]) + $urandom_range(0, 2) - 1;
    if (near > 255) near = 255 - $urandom_range(0, 2);
    return near[7:0];
  endfunction

  initial begin
    logic [7:0] directed_cycles [$];
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Timer off after reset: only the divider moves, including a carry.
    directed_cycles = '{8'd0, 8'd255, 8'd255, 8'd1};
    foreach (directed_cycles[i]) send_instruction(directed_cycles[i]);
    drain();

    // Fast period: a step just short of, exactly at, and far past the period.
    program_register(CFG_TIMER_ENABLE, 8'h01);
    program_register(CFG_CLOCK_SELECT, {6'd0, SEL_16});
    program_register(CFG_RELOAD_VALUE, COUNT_MAX);
    directed_cycles = '{8'd15, 8'd1, 8'd16, 8'd255, 8'd0};
    foreach (directed_cycles[i]) send_instruction(directed_cycles[i]);
    drain();

    // Slowest period: four long steps stay short of 1024, the fifth hits it.
    program_register(CFG_CLOCK_SELECT, {6'd0, SEL_1024});
    directed_cycles = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd4};
    foreach (directed_cycles[i]) send_instruction(directed_cycles[i]);
    drain();

    program_register(CFG_CLOCK_SELECT, {6'd0, SEL_64});
    directed_cycles = '{8'd64, 8'd63, 8'd1};
    foreach (directed_cycles[i]) send_instruction(directed_cycles[i]);
    drain();

    program_register(CFG_CLOCK_SELECT, {6'd0, SEL_256});
    directed_cycles = '{8'd255, 8'd1};
    foreach (directed_cycles[i]) send_instruction(directed_cycles[i]);
    drain();

    // Timer off with a select change; the period still restarts. Upper data
    // bits set and a write to the spare index must not disturb anything.
    program_register(CFG_TIMER_ENABLE, 8'hFE);
    program_register(CFG_CLOCK_SELECT, 8'hFD);
    program_register(CFG_SPARE, 8'hFF);
    directed_cycles = '{8'd200, 8'd100};
    foreach (directed_cycles[i]) send_instruction(directed_cycles[i]);
    drain();

    // Random phases: new settings between phases, extremes in the first ones.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      logic       en;
      logic [1:0] sel;
      logic [7:0] rl;
      en  = (phase == 5 || phase == 9) ? 1'b0 : 1'b1;
      sel = (phase < 4) ? phase[1:0] :
            ($urandom_range(0, 1) ? SEL_16 : 2'($urandom_range(0, 3)));
      case ($urandom_range(0, 3))
        0: rl = 8'd0;
        1: rl = COUNT_MAX;
        2: rl = COUNT_MAX - 8'($urandom_range(1, 4));
        default: rl = 8'($urandom_range(0, 255));
      endcase
      if (phase == 0) rl = COUNT_MAX;
      if (phase == 1) rl = 8'd0;
      program_register(CFG_TIMER_ENABLE, {7'($urandom_range(0, 127)), en});
      if (phase < 4 || $urandom_range(0, 3) != 0)
        program_register(CFG_CLOCK_SELECT, {6'($urandom_range(0, 63)), sel});
      if (phase < 2 || $urandom_range(0, 3) != 0) program_register(CFG_RELOAD_VALUE, rl);
      if ($urandom_range(0, 2) == 0) program_register(CFG_SPARE, 8'($urandom_range(0, 255)));
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) send_instruction(pick_cycles());
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("Covered %0d instructions over %0d register writes, all four periods,",
             instructions_sent, reg_writes);
    $display("timer on and off; %0d results checked, %0d overflow pulses seen.",
             sb.checked, sb.irqs);
    if (sb.errors == 0 && sb.pending_snapshots.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/hct_pkg.sv
hdl/hct_div.sv
hdl/hct_timer.sv
hdl/handheld_console_timer_top.sv
tb/sv/tb.sv
